>>> rtl/core/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, codes and constants of the spin drift timing block.
// ----------------------------------------------------------------------------
package sdt_pkg;

  localparam int TIME_BITS = 24;
  // divider width: covers the widest numerator and the effective radius
  localparam int DIV_W = (TIME_BITS + 7 > 34) ? TIME_BITS + 7 : 34;
  localparam int SUM_W = DIV_W + 2;
  localparam int PADDR_W = 5;

  localparam int RADIUS_RESET = 256;
  localparam int OFFSET_RESET = 0;
  localparam int RANGE_RESET = 500;
  localparam int HDIV_RESET = 16;
  localparam int TMAX_RESET = 150000;

  localparam int RADIUS_MAX = 65535;
  localparam int RADIUS_MIN = 51;
  localparam int OFFSET_MAX = 25600;
  localparam int RPM_GAIN = 89445;
  localparam int US_PER_MIN = 60000000;
  localparam int RADIUS_STEP_DIV = 50;
  localparam int OFFSET_STEP_GAIN = 640;
  localparam int PCT_FULL = 100;
  localparam int LED_BASE_PCT = 110;
  localparam int LED_DIV = 250;

  // reciprocals for exact division of numerators below 2^31
  localparam int RECIP_100 = 1374389535;
  localparam int RECIP_250 = 549755814;
  localparam int RECIP_SHIFT = 37;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_BACK = 2'd2;
  localparam logic [1:0] DIR_UNUSED = 2'd3;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_RANGE = 3'd2;
  localparam logic [2:0] REG_HDIV = 3'd3;
  localparam logic [2:0] REG_TMAX = 3'd4;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_TOGGLE,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    X_NONE,
    X_RADIUS,
    X_OFFSET,
    X_STEER
  } xkind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XSET,
    ST_XDIV,
    ST_XAPPLY,
    ST_RSET,
    ST_RDIV,
    ST_SQRT,
    ST_PDIV,
    ST_PCLAMP,
    ST_MSET,
    ST_MDIV,
    ST_LSET,
    ST_LDIV,
    ST_OSET,
    ST_ODIV,
    ST_EDGES,
    ST_REPLY
  } back_state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [23:0]        elapsed_us;
    logic signed [15:0] accel_force;
    logic signed [11:0] stick_offset;
    logic [6:0]         throttle_pct;
    logic [1:0]         direction;
    logic               in_deadzone;
    logic               battery_low;
  } in_item_t;

  typedef struct packed {
    logic        motor1_on;
    logic        motor2_on;
    logic        led_on;
    logic        led_flicker;
    logic        rotation_done;
    logic [23:0] period_us;
    logic [15:0] peak_rpm;
    logic        config_active;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [23:0]        elapsed_us;
    logic signed [15:0] accel;
    logic signed [11:0] stick;
    logic [6:0]         thr;
    logic [1:0]         dir;
    logic               dead;
    logic               batt;
  } cmd_t;

  typedef struct packed {
    logic [10:0] range;
    logic [7:0]  hdiv;
    logic [22:0] tmax;
    logic        ld_radius;
    logic [15:0] radius_val;
    logic        ld_offset;
    logic [14:0] offset_val;
  } cfg_t;

endpackage

>>> rtl/core/sdt_ifs.sv
// ----------------------------------------------------------------------------
// sdt stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sdt_in_if import sdt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sdt_out_if import sdt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/sdt_divider.sv
// ----------------------------------------------------------------------------
// sdt_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdt_divider import sdt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = CNT_W'(DIV_W - 1);
      rem_nxt = '0;
      quo_nxt = num;
      den_nxt = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_W'(rem_sh - {1'b0, den_r}) : DIV_W'(rem_sh);
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo = quo_r;

endmodule

>>> rtl/core/sdt_cmd_queue.sv
// ----------------------------------------------------------------------------
// sdt_cmd_queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module sdt_cmd_queue import sdt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  assign full = cnt_r[1];
  assign head_valid = cnt_r != 2'd0;
  assign head = mem_r[rd_ptr_r];

endmodule

>>> rtl/core/sdt_front.sv
// ----------------------------------------------------------------------------
// sdt_front
// Accepts input items, decodes the mode and normalizes the fields.
// ----------------------------------------------------------------------------
module sdt_front import sdt_pkg::*; (
  sdt_in_if.sink in_stream,
  input  logic   q_full,
  output logic   push,
  output cmd_t   push_cmd
);

  in_item_t d;

  assign d = in_stream.data;
  assign in_stream.ready = !q_full;
  assign push = in_stream.valid && !q_full;

  always_comb begin
    unique case (d.mode)
      MODE_TICK:   push_cmd.kind = CMD_TICK;
      MODE_START:  push_cmd.kind = CMD_START;
      MODE_TOGGLE: push_cmd.kind = CMD_TOGGLE;
      default:     push_cmd.kind = CMD_NOP;
    endcase
    push_cmd.elapsed_us = d.elapsed_us;
    push_cmd.accel = d.accel_force;
    push_cmd.stick = d.stick_offset;
    push_cmd.thr = (d.throttle_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL) : d.throttle_pct;
    push_cmd.dir = (d.direction == DIR_UNUSED) ? DIR_NEUTRAL : d.direction;
    push_cmd.dead = d.in_deadzone;
    push_cmd.batt = d.battery_low;
  end

endmodule

>>> rtl/core/sdt_back.sv
// ----------------------------------------------------------------------------
// sdt_back
// Executes commands: tick drive, mode toggle, unused-mode reply and the rotation start sequence
// ----------------------------------------------------------------------------
module sdt_back import sdt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  sdt_out_if.source  out_stream
);

  localparam int TW = TIME_BITS;

  back_state_t state_r, state_nxt;

  logic             div_start, div_busy, div_done;
  logic [DIV_W-1:0] div_quo;

  // architectural state
  logic [15:0]   radius_r;
  logic [14:0]   offset_r;
  logic [15:0]   peak_r;
  logic          config_on_r;
  logic          parity_r;
  logic [TW-1:0] period_r;
  logic [TW-1:0] m1_lo_r, m1_hi_r, m2_lo_r, m2_hi_r, led_lo_r, led_hi_r;
  logic [1:0]    act_dir_r;
  logic          shimmer_r;

  // start sequence working registers
  cmd_t             cur_r;
  xkind_t           xkind_r;
  logic             neg_r;
  logic             cshim_r;
  logic [1:0]       dir_eff_r;
  logic [DIV_W-1:0] num_r, den_r, reff_r;
  logic [31:0]      sq_x_r;
  logic [18:0]      sq_rem_r;
  logic [15:0]      sq_root_r;
  logic [3:0]       sq_cnt_r;
  logic [TW-1:0]    p_r, m_r, l_r, o_r;
  logic             full_r;

  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          out_free, out_load;
  out_item_t     out_nxt;

  sdt_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid_r || out_stream.ready;

  // ---------------- command decode for the start sequence
  logic   cfg_neutral, cfg_back;
  xkind_t xk_sel;
  logic [11:0] smag;
  logic [15:0] amag;

  assign cfg_neutral = config_on_r && (cur_r.dir == DIR_NEUTRAL);
  assign cfg_back = config_on_r && (cur_r.dir == DIR_BACK);
  assign smag = cur_r.stick[11] ? 12'(-cur_r.stick) : cur_r.stick;
  assign amag = cur_r.accel[15] ? 16'(-cur_r.accel) : cur_r.accel;

  always_comb begin
    priority if (cfg_neutral) xk_sel = cur_r.dead ? X_NONE : X_RADIUS;
    else if (cfg_back) xk_sel = cur_r.dead ? X_NONE : X_OFFSET;
    else xk_sel = X_STEER;
  end

  // ---------------- products (each feeds a register)
  logic [27:0]    prod_rs;
  logic [16:0]    den_rad;
  logic [20:0]    prod_off;
  logic [18:0]    den_steer;
  logic [32:0]    prod_rpm;
  logic [TW+6:0]  prod_m, prod_l;
  logic [TW+14:0] prod_o;
  logic [6:0]     thr_led;

  assign prod_rs = radius_r * smag;
  assign den_rad = cfg.range * 17'(RADIUS_STEP_DIV);
  assign prod_off = smag * 21'(OFFSET_STEP_GAIN);
  assign den_steer = cfg.range * cfg.hdiv;
  assign prod_rpm = amag * 33'(RPM_GAIN);
  assign thr_led = 7'(7'(LED_BASE_PCT) - cur_r.thr);
  assign prod_m = p_r * cur_r.thr;
  assign prod_l = p_r * thr_led;
  assign prod_o = p_r * offset_r;

  // ---------------- division by 100 or 250 through a reciprocal
  logic [30:0]   rcp_k;
  logic [61:0]   rcp_prod;
  logic [TW-1:0] rcp_q;

  assign rcp_k = (state_r == ST_LDIV) ? 31'(RECIP_250) : 31'(RECIP_100);
  assign rcp_prod = num_r[30:0] * rcp_k;
  assign rcp_q = TW'(rcp_prod[61:RECIP_SHIFT]);

  // ---------------- signed adjust of radius / offset / effective radius
  logic [15:0]              base_u;
  logic signed [SUM_W-1:0]  base_s, q_s, sum_s;

  assign base_u = (xkind_r == X_OFFSET) ? {1'b0, offset_r} : radius_r;
  assign base_s = $signed({{(SUM_W-16){1'b0}}, base_u});
  assign q_s = $signed({2'b00, div_quo});
  assign sum_s = neg_r ? base_s - q_s : base_s + q_s;

  // ---------------- square root step
  logic [18:0] sq_rem_sh, sq_trial;
  logic        sq_ge;
  logic [18:0] sq_rem_nxt;
  logic [15:0] sq_root_nxt;

  assign sq_rem_sh = {sq_rem_r[16:0], sq_x_r[31:30]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign sq_ge = sq_rem_sh >= sq_trial;
  assign sq_rem_nxt = sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
  assign sq_root_nxt = {sq_root_r[14:0], sq_ge};

  // ---------------- period clamp
  logic [DIV_W-1:0] p_raw, p_c1, p_c2, tmax_w, tmax2_w, mask_w;

  assign tmax_w = DIV_W'(cfg.tmax);
  assign tmax2_w = DIV_W'({cfg.tmax, 1'b0});
  assign mask_w = DIV_W'({TW{1'b1}});
  assign p_raw = (den_r == '0) ? '1 : div_quo;
  assign p_c1 = (p_raw > tmax2_w) ? tmax2_w : p_raw;
  assign p_c2 = (p_c1 > mask_w) ? mask_w : p_c1;

  // ---------------- window edges
  logic [TW-1:0] mh, lh, e0, ls;
  logic [TW:0]   ls_wrap, le_w;

  assign mh = m_r >> 1;
  assign lh = l_r >> 1;
  assign e0 = (p_r - m_r) >> 1;
  assign ls_wrap = {1'b0, p_r} + {1'b0, o_r} - {1'b0, lh};
  assign ls = (lh <= o_r) ? o_r - lh : TW'(ls_wrap);
  assign le_w = {1'b0, ls} + {1'b0, l_r};

  // ---------------- tick evaluation
  logic [TW-1:0] t;
  logic          t_done, w1, w2, fwd, led_win;

  assign t = TW'(q_head.elapsed_us);
  assign t_done = t >= period_r;
  assign w1 = (t >= m1_lo_r) && (t <= m1_hi_r);
  assign w2 = (t >= m2_lo_r) || (t <= m2_hi_r);
  assign fwd = (act_dir_r == DIR_FWD) || ((act_dir_r == DIR_NEUTRAL) && !parity_r);
  assign led_win = (led_lo_r > led_hi_r) ? ((t >= led_lo_r) || (t <= led_hi_r))
                                         : ((t >= led_lo_r) && (t <= led_hi_r));

  // ---------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid && q_head.kind == CMD_START) state_nxt = ST_XSET;
      ST_XSET:   state_nxt = (xk_sel == X_NONE) ? ST_RSET : ST_XDIV;
      ST_XDIV:   if (div_done) state_nxt = ST_XAPPLY;
      ST_XAPPLY: state_nxt = ST_RSET;
      ST_RSET:   state_nxt = ST_RDIV;
      ST_RDIV:   if (div_done) state_nxt = ST_SQRT;
      ST_SQRT:   if (sq_cnt_r == 4'd15) state_nxt = ST_PDIV;
      ST_PDIV:   if (den_r == '0 || div_done) state_nxt = ST_PCLAMP;
      ST_PCLAMP: state_nxt = ST_MSET;
      ST_MSET:   state_nxt = ST_MDIV;
      ST_MDIV:   state_nxt = ST_LSET;
      ST_LSET:   state_nxt = ST_LDIV;
      ST_LDIV:   state_nxt = ST_OSET;
      ST_OSET:   state_nxt = ST_ODIV;
      ST_ODIV:   state_nxt = ST_EDGES;
      ST_EDGES:  state_nxt = ST_REPLY;
      ST_REPLY:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- control outputs
  logic div_state;

  always_comb begin
    div_state = (state_r == ST_XDIV) || (state_r == ST_RDIV) ||
                ((state_r == ST_PDIV) && (den_r != '0));
    div_start = div_state && !div_busy && !div_done;
    q_pop = 1'b0;
    out_load = 1'b0;
    out_nxt.motor1_on = 1'b0;
    out_nxt.motor2_on = 1'b0;
    out_nxt.led_on = 1'b0;
    out_nxt.led_flicker = shimmer_r;
    out_nxt.rotation_done = 1'b0;
    out_nxt.period_us = 24'(period_r);
    out_nxt.peak_rpm = peak_r;
    out_nxt.config_active = config_on_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == CMD_START) begin
            q_pop = 1'b1;
          end else if (out_free) begin
            q_pop = 1'b1;
            out_load = 1'b1;
            unique case (q_head.kind)
              CMD_TICK: begin
                out_nxt.rotation_done = t_done;
                if (!t_done) begin
                  out_nxt.motor1_on = fwd ? w1 : w2;
                  out_nxt.motor2_on = fwd ? w2 : w1;
                  out_nxt.led_on = led_win;
                end
              end
              CMD_TOGGLE: begin
                out_nxt.peak_rpm = '0;
                out_nxt.config_active = !config_on_r;
              end
              default: ;
            endcase
          end
        end
      end
      ST_REPLY: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------- state register and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      radius_r <= 16'(RADIUS_RESET);
      offset_r <= 15'(OFFSET_RESET);
      peak_r <= '0;
      config_on_r <= 1'b0;
      parity_r <= 1'b0;
      period_r <= '0;
      m1_lo_r <= '0;
      m1_hi_r <= '0;
      m2_lo_r <= '0;
      m2_hi_r <= '0;
      led_lo_r <= '0;
      led_hi_r <= '0;
      act_dir_r <= DIR_NEUTRAL;
      shimmer_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_stream.ready) out_valid_r <= 1'b0;

      if (cfg.ld_radius) radius_r <= cfg.radius_val;
      if (cfg.ld_offset) begin
        offset_r <= (cfg.offset_val > 15'(OFFSET_MAX)) ? 15'(OFFSET_MAX) : cfg.offset_val;
      end

      if (q_pop && q_head.kind == CMD_START) parity_r <= !parity_r;
      if (q_pop && q_head.kind == CMD_TOGGLE) begin
        config_on_r <= !config_on_r;
        peak_r <= '0;
      end

      if (state_r == ST_XAPPLY) begin
        unique case (xkind_r)
          X_RADIUS: begin
            priority if (sum_s > SUM_W'(RADIUS_MAX)) radius_r <= 16'(RADIUS_MAX);
            else if (sum_s < SUM_W'(RADIUS_MIN)) radius_r <= 16'(RADIUS_MIN);
            else radius_r <= 16'(sum_s);
          end
          X_OFFSET: begin
            priority if (sum_s > SUM_W'(OFFSET_MAX)) offset_r <= '0;
            else if (sum_s < SUM_W'(0)) offset_r <= 15'(OFFSET_MAX);
            else offset_r <= 15'(sum_s);
          end
          default: ;
        endcase
      end

      if (state_r == ST_SQRT && sq_cnt_r == 4'd15) begin
        if (sq_root_nxt > peak_r || peak_r == '0) peak_r <= sq_root_nxt;
      end

      if (state_r == ST_EDGES) begin
        period_r <= p_r;
        m1_lo_r <= e0;
        m1_hi_r <= e0 + m_r;
        m2_lo_r <= p_r - mh;
        m2_hi_r <= mh;
        led_lo_r <= ls;
        led_hi_r <= (le_w > {1'b0, p_r}) ? TW'(le_w - {1'b0, p_r}) : TW'(le_w);
        act_dir_r <= dir_eff_r;
        shimmer_r <= cshim_r || cur_r.batt;
      end
    end

    if (out_load) out_data_r <= out_nxt;

    if (q_pop) cur_r <= q_head;

    unique case (state_r)
      ST_XSET: begin
        xkind_r <= xk_sel;
        neg_r <= cur_r.stick[11];
        cshim_r <= (cfg_neutral || cfg_back) && !cur_r.dead;
        dir_eff_r <= cfg_back ? DIR_NEUTRAL : cur_r.dir;
        reff_r <= DIV_W'(radius_r);
        unique case (xk_sel)
          X_RADIUS: begin
            num_r <= DIV_W'(prod_rs);
            den_r <= DIV_W'(den_rad);
          end
          X_OFFSET: begin
            num_r <= DIV_W'(prod_off);
            den_r <= DIV_W'(cfg.range);
          end
          X_STEER: begin
            num_r <= DIV_W'({prod_rs, 4'b0000});
            den_r <= DIV_W'(den_steer);
          end
          default: ;
        endcase
      end
      ST_XAPPLY: begin
        unique case (xkind_r)
          X_RADIUS: begin
            priority if (sum_s > SUM_W'(RADIUS_MAX)) reff_r <= DIV_W'(RADIUS_MAX);
            else if (sum_s < SUM_W'(RADIUS_MIN)) reff_r <= DIV_W'(RADIUS_MIN);
            else reff_r <= DIV_W'(sum_s);
          end
          X_STEER: reff_r <= (sum_s < SUM_W'(1)) ? DIV_W'(1) : DIV_W'(sum_s);
          default: ;
        endcase
      end
      ST_RSET: begin
        num_r <= DIV_W'(prod_rpm);
        den_r <= reff_r;
      end
      ST_RDIV: begin
        sq_x_r <= 32'(div_quo);
        sq_rem_r <= '0;
        sq_root_r <= '0;
        sq_cnt_r <= '0;
      end
      ST_SQRT: begin
        sq_x_r <= {sq_x_r[29:0], 2'b00};
        sq_rem_r <= sq_rem_nxt;
        sq_root_r <= sq_root_nxt;
        sq_cnt_r <= sq_cnt_r + 4'd1;
        num_r <= DIV_W'(US_PER_MIN);
        den_r <= DIV_W'(sq_root_nxt);
      end
      ST_PCLAMP: begin
        full_r <= p_raw > tmax_w;
        p_r <= TW'(p_c2);
      end
      ST_MSET: num_r <= DIV_W'(prod_m);
      ST_MDIV: m_r <= full_r ? p_r : rcp_q;
      ST_LSET: num_r <= DIV_W'(prod_l);
      ST_LDIV: l_r <= rcp_q;
      // offset is in 1/256 percent: drop 8 bits, then divide by 100
      ST_OSET: num_r <= DIV_W'(prod_o[TW+14:8]);
      ST_ODIV: o_r <= rcp_q;
      default: ;
    endcase
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.data = out_data_r;

endmodule

>>> rtl/core/spin_drift_timing_core.sv
// ----------------------------------------------------------------------------
// spin_drift_timing_core
// Spin drift drive timing: register port, front end, queue and back end.
// ----------------------------------------------------------------------------
// Each item is decoded in the front end and waits in a two-entry queue for
// the back end. A tick, mode toggle or unused mode is answered through the
// output register once it is at the head of the queue and that register is
// free; ticks run at one item per cycle while results are taken. A rotation
// start runs a sequence around one shared restoring divider: up to three
// divides, a 16-step square root, the period clamp, the motor, LED and offset
// shares, the window edges and the reply, while later items queue up (the
// config-mode nudge divide is skipped in the deadzone). The shares divide by
// reciprocal multiplication. Results leave through an output register; a start
// sequence runs on while an earlier result waits. A start command is taken at
// once, other commands only when the output register is free.
module spin_drift_timing_core import sdt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  sdt_in_if.sink             in_stream,
  sdt_out_if.source          out_stream,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [15:0] init_radius_r;
  logic [14:0] init_offset_r;
  logic [10:0] range_r;
  logic [7:0]  hdiv_r;
  logic [22:0] tmax_r;
  logic        wr_en;
  logic [2:0]  reg_idx;
  cfg_t        cfg;

  logic push, q_full, q_pop, q_valid;
  cmd_t push_cmd, q_head;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[4:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_radius_r <= 16'(RADIUS_RESET);
      init_offset_r <= 15'(OFFSET_RESET);
      range_r <= 11'(RANGE_RESET);
      hdiv_r <= 8'(HDIV_RESET);
      tmax_r <= 23'(TMAX_RESET);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RADIUS: init_radius_r <= cfg_pwdata[15:0];
        REG_OFFSET: init_offset_r <= cfg_pwdata[14:0];
        REG_RANGE:  range_r <= cfg_pwdata[10:0];
        REG_HDIV:   hdiv_r <= cfg_pwdata[7:0];
        REG_TMAX:   tmax_r <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RADIUS: cfg_prdata = 32'(init_radius_r);
      REG_OFFSET: cfg_prdata = 32'(init_offset_r);
      REG_RANGE:  cfg_prdata = 32'(range_r);
      REG_HDIV:   cfg_prdata = 32'(hdiv_r);
      REG_TMAX:   cfg_prdata = 32'(tmax_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // zero range or divisor behaves as one
  always_comb begin
    cfg.range = (range_r == '0) ? 11'd1 : range_r;
    cfg.hdiv = (hdiv_r == '0) ? 8'd1 : hdiv_r;
    cfg.tmax = tmax_r;
    cfg.ld_radius = wr_en && (reg_idx == REG_RADIUS);
    cfg.radius_val = cfg_pwdata[15:0];
    cfg.ld_offset = wr_en && (reg_idx == REG_OFFSET);
    cfg.offset_val = cfg_pwdata[14:0];
  end

  sdt_front u_front (
    .in_stream (in_stream),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sdt_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sdt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule
